[src/sgr_pkg.sv]
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants for the stream group reverser.
// ----------------------------------------------------------------------------
package sgr_pkg;

    // Default largest group, and the fixed widths of the stream fields.
    localparam int MAX_GROUP_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int CFG_W         = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;

    // Flags that travel with each finished group from the front to the back.
    typedef struct packed {
        logic bank;      // buffer bank that holds the group
        logic reversed;  // emit newest first
        logic ends;      // the group closes the list
    } t_job_flags;

    localparam int FLAGS_W = $bits(t_job_flags);

    // Bank release from the back once a group is fully drained.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    // Back end sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_DRAIN
    } t_back_state;

endpackage

[src/stream_group_reverser.sv]
// ----------------------------------------------------------------------------
// stream_group_reverser
// Reverses a stream in groups of a configured size; a partial group at the
// end of a list is passed on in its original order.
// ----------------------------------------------------------------------------
//  Channel   Direction  Moves
//  s_axis    in         item value (tdata), list end (tlast)
//  m_axis    out        value (tdata), last of run (tlast), list end (tuser)
//  cfg       in         group size, 5 bits
//
// The input takes one transaction per cycle while the bank it fills is free and
// the queue has room; there are two banks, so one group drains while the next
// one fills. A closed group drains one result per cycle while the output is not
// stalled; the drain is set by the single buffer read. Reset is synchronous and
// clears the control state; the buffer is not cleared. Output stalls hold the
// output register and then the input side.
// ----------------------------------------------------------------------------
module stream_group_reverser #(
    parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [sgr_pkg::CFG_W-1:0]  i_cfg_data,   // group_size
    // input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,  // item_value
    input  logic                       s_axis_tlast,  // list_end
    // output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,  // out_value
    output logic                       m_axis_tlast,  // run_last
    output logic                       m_axis_tuser   // out_list_end
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int JW = CW + sgr_pkg::FLAGS_W;

    logic                        wr_en;
    logic [IW:0]                 wr_addr;
    logic [sgr_pkg::DATA_W-1:0]  wr_data;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_valid;
    logic                        q_full;
    logic [CW-1:0]               push_count;
    sgr_pkg::t_job_flags         push_flags;
    logic [JW-1:0]               q_in;
    logic [JW-1:0]               q_out;
    sgr_pkg::t_release           rel;

    assign o_cfg_ready = 1'b1;

    // Front end: accepts items and closes groups.
    sgr_front #(
        .MAX_GROUP (MAX_GROUP),
        .CW        (CW),
        .IW        (IW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_value      (s_axis_tdata),
        .i_end        (s_axis_tlast),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_push       (q_push),
        .o_push_count (push_count),
        .o_push_flags (push_flags),
        .i_q_full     (q_full),
        .i_rel        (rel)
    );

    // Descriptor queue between the two ends.
    assign q_in = {push_count, push_flags};

    sgr_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_out)
    );

    // Back end: drains groups from the buffer.
    sgr_back #(
        .MAX_GROUP (MAX_GROUP),
        .CW        (CW),
        .IW        (IW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_q_valid  (q_valid),
        .i_q_count  (q_out[JW-1:sgr_pkg::FLAGS_W]),
        .i_q_flags  (sgr_pkg::t_job_flags'(q_out[sgr_pkg::FLAGS_W-1:0])),
        .o_pop      (q_pop),
        .o_rel      (rel),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_value    (m_axis_tdata),
        .o_run_last (m_axis_tlast),
        .o_list_end (m_axis_tuser)
    );

    // The queue never overflows: bank ownership bounds open groups to two.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (!q_full || q_pop))
        else $error("descriptor pushed into a full queue");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("descriptor popped from an empty queue");

    // The list end is only ever flagged on the last result of a run.
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("list end flagged inside a run");

    // A bank release is followed by the closing result of its group on the output.
    a_release_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rel.valid |=> (m_axis_tvalid && m_axis_tlast))
        else $error("bank released without a closing result");

endmodule

[src/sgr_queue.sv]
// ----------------------------------------------------------------------------
// sgr_queue
// Two-entry queue of group descriptors between the front and the back.
// ----------------------------------------------------------------------------
module sgr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];

    // Entry storage; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

[src/sgr_front.sv]
// ----------------------------------------------------------------------------
// sgr_front
// Accepts items, writes them into the current bank and closes groups.
// ----------------------------------------------------------------------------
module sgr_front #(
    parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF,
    parameter int CW        = $clog2(MAX_GROUP + 1),
    parameter int IW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_valid,
    input  logic [sgr_pkg::CFG_W-1:0]   i_cfg_data,
    // input items
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sgr_pkg::DATA_W-1:0]  i_value,
    input  logic                        i_end,
    // buffer write port
    output logic                        o_wr_en,
    output logic [IW:0]                 o_wr_addr,
    output logic [sgr_pkg::DATA_W-1:0]  o_wr_data,
    // descriptor queue
    output logic                        o_push,
    output logic [CW-1:0]               o_push_count,
    output sgr_pkg::t_job_flags         o_push_flags,
    input  logic                        i_q_full,
    // bank release from the back
    input  sgr_pkg::t_release           i_rel
);

    logic [sgr_pkg::CFG_W-1:0] r_group_size;
    logic [CW-1:0]             r_fill;
    logic                      r_wr_bank;
    logic [1:0]                r_busy;

    logic [CW-1:0] n_fill;
    logic          n_wr_bank;
    logic [1:0]    n_busy;
    logic [CW-1:0] eff_size;
    logic [CW-1:0] count;
    logic          accept;
    logic          full_group;

    // Group size clamped into 1..MAX_GROUP.
    always_comb begin
        if (r_group_size == '0) begin
            eff_size = CW'(1);
        end else if (32'(r_group_size) > 32'(MAX_GROUP)) begin
            eff_size = CW'(MAX_GROUP);
        end else begin
            eff_size = CW'(r_group_size);
        end
    end

    // An item is taken only while its bank is free for writing.
    assign o_ready    = !r_busy[r_wr_bank] && !i_q_full;
    assign accept     = i_valid && o_ready;
    assign count      = r_fill + CW'(1);
    assign full_group = (count >= eff_size);

    assign o_wr_en   = accept;
    assign o_wr_addr = {r_wr_bank, r_fill[IW-1:0]};
    assign o_wr_data = i_value;

    assign o_push                = accept && (full_group || i_end);
    assign o_push_count          = count;
    assign o_push_flags.bank     = r_wr_bank;
    assign o_push_flags.reversed = full_group;
    assign o_push_flags.ends     = i_end;

    // Fill count, bank toggle and bank ownership.
    always_comb begin
        n_fill    = r_fill;
        n_wr_bank = r_wr_bank;
        n_busy    = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (o_push) begin
            n_fill            = '0;
            n_wr_bank         = ~r_wr_bank;
            n_busy[r_wr_bank] = 1'b1;
        end else if (accept) begin
            n_fill = count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= sgr_pkg::CFG_RESET;
            r_fill       <= '0;
            r_wr_bank    <= 1'b0;
            r_busy       <= 2'b00;
        end else begin
            if (i_cfg_valid) begin
                r_group_size <= i_cfg_data;
            end
            r_fill    <= n_fill;
            r_wr_bank <= n_wr_bank;
            r_busy    <= n_busy;
        end
    end

endmodule

[src/sgr_back.sv]
// ----------------------------------------------------------------------------
// sgr_back
// Holds the two-bank group buffer and drains finished groups to the output.
// ----------------------------------------------------------------------------
module sgr_back #(
    parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF,
    parameter int CW        = $clog2(MAX_GROUP + 1),
    parameter int IW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // buffer write port
    input  logic                        i_wr_en,
    input  logic [IW:0]                 i_wr_addr,
    input  logic [sgr_pkg::DATA_W-1:0]  i_wr_data,
    // descriptor queue
    input  logic                        i_q_valid,
    input  logic [CW-1:0]               i_q_count,
    input  sgr_pkg::t_job_flags         i_q_flags,
    output logic                        o_pop,
    // bank release to the front
    output sgr_pkg::t_release           o_rel,
    // results
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sgr_pkg::DATA_W-1:0]  o_value,
    output logic                        o_run_last,
    output logic                        o_list_end
);

    localparam int DEPTH = 2 ** (IW + 1);

    logic [sgr_pkg::DATA_W-1:0] r_mem [DEPTH];

    sgr_pkg::t_back_state r_state;
    sgr_pkg::t_back_state n_state;
    sgr_pkg::t_job_flags  r_flags;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_k;

    logic                       r_out_valid;
    logic [sgr_pkg::DATA_W-1:0] r_out_value;
    logic                       r_out_run_last;
    logic                       r_out_list_end;

    logic          adv;
    logic          last;
    logic          load;
    logic [CW-1:0] idx;
    logic [IW:0]   rd_addr;

    // Sequencing of one group: read one entry per advancing cycle.
    assign adv     = (r_state == sgr_pkg::BK_DRAIN) && (!r_out_valid || i_ready);
    assign last    = (r_k == (r_count - CW'(1)));
    assign load    = i_q_valid && ((r_state == sgr_pkg::BK_IDLE) || (adv && last));
    assign idx     = r_flags.reversed ? (r_count - CW'(1) - r_k) : r_k;
    assign rd_addr = {r_flags.bank, idx[IW-1:0]};

    assign o_pop      = load;
    assign o_rel.valid = adv && last;
    assign o_rel.bank  = r_flags.bank;

    assign o_valid    = r_out_valid;
    assign o_value    = r_out_value;
    assign o_run_last = r_out_run_last;
    assign o_list_end = r_out_list_end;

    // Next state of the drain sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sgr_pkg::BK_IDLE: begin
                if (load) begin
                    n_state = sgr_pkg::BK_DRAIN;
                end
            end
            sgr_pkg::BK_DRAIN: begin
                if (adv && last && !load) begin
                    n_state = sgr_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = sgr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgr_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Buffer write from the front.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered buffer read straight into the output register.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_value    <= r_mem[rd_addr];
            r_out_run_last <= last;
            r_out_list_end <= last && r_flags.ends;
        end
    end

    // Group descriptor and position.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_flags <= i_q_flags;
            r_count <= i_q_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k <= '0;
            end else if (adv) begin
                r_k <= r_k + CW'(1);
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
